FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MPR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MPR_ASSERT(lbl, clk, rst_n, prop)
`define MPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/mpr_pkg.sv
// ----------------------------------------------------------------------------
// mpr_pkg
// shared types and constants of the multiset permutation rank core
// ----------------------------------------------------------------------------
package mpr_pkg;

    localparam int SYM_W     = 8;
    localparam int RANK_W    = 62;
    localparam int LEN_W     = 5;
    localparam int PROD_W    = RANK_W + LEN_W + 1;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = PROD_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int DATA_W    = 64;

    localparam logic [0:0] REG_SEQ_LEN    = 1'b0;
    localparam logic [0:0] REG_GROUP_SIZE = 1'b1;

    localparam logic [LEN_W-1:0] SEQ_LEN_RST    = 5'd20;
    localparam logic [LEN_W-1:0] GROUP_SIZE_RST = 5'd1;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_INIT_MUL,
        ST_INIT_WAIT,
        ST_IDLE,
        ST_SUM,
        ST_RANK_MUL,
        ST_RANK_WAIT,
        ST_NEXT_MUL,
        ST_NEXT_WAIT,
        ST_ADVANCE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        GF_HOLD,
        GF_CLR,
        GF_INC,
        GF_DEC
    } t_gf_op;

    typedef struct packed {
        logic              start;
        logic [RANK_W-1:0] a;
        logic [LEN_W-1:0]  b;
        logic [LEN_W-1:0]  c;
    } t_md_req;

    typedef struct packed {
        logic              done;
        logic [RANK_W-1:0] quot;
    } t_md_rsp;

    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
        logic              failed;
    } t_result;

endpackage

FILE: rtl/core/mpr_muldiv.sv
// ----------------------------------------------------------------------------
// mpr_muldiv
// shared unit: q = a * b / c, exact divide, four quotient bits per cycle
// ----------------------------------------------------------------------------
module mpr_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mpr_pkg::t_md_req i_req,
    output mpr_pkg::t_md_rsp o_rsp
);

    localparam int MW = mpr_pkg::RANK_W + mpr_pkg::LEN_W;

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [mpr_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [mpr_pkg::PROD_W-1:0]      r_q, n_q;
    logic [mpr_pkg::LEN_W-1:0]       r_rem, n_rem;
    logic [mpr_pkg::LEN_W-1:0]       r_div, n_div;
    logic [MW-1:0]                   w_prod;

    assign w_prod = MW'(i_req.a) * MW'(i_req.b);

    always_comb begin
        logic [mpr_pkg::LEN_W:0]    rem6;
        logic [mpr_pkg::LEN_W-1:0]  rem;
        logic [mpr_pkg::PROD_W-1:0] q;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        rem    = r_rem;
        q      = r_q;
        rem6   = '0;
        if (i_req.start) begin
            n_q    = {1'b0, w_prod};
            n_rem  = '0;
            n_div  = i_req.c;
            n_cnt  = mpr_pkg::DIV_CNT_W'(mpr_pkg::DIV_STEPS - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // restoring steps, quotient bits shift in behind the dividend
            for (int i = 0; i < mpr_pkg::DIV_BITS; i++) begin
                rem6 = {rem, q[mpr_pkg::PROD_W-1]};
                if (rem6 >= {1'b0, r_div}) begin
                    rem6 = rem6 - {1'b0, r_div};
                    q    = {q[mpr_pkg::PROD_W-2:0], 1'b1};
                end else begin
                    q    = {q[mpr_pkg::PROD_W-2:0], 1'b0};
                end
                rem = rem6[mpr_pkg::LEN_W-1:0];
            end
            n_q   = q;
            n_rem = rem;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q[mpr_pkg::RANK_W-1:0];

endmodule

FILE: rtl/core/mpr_group_file.sv
// ----------------------------------------------------------------------------
// mpr_group_file
// remaining copies per color, one shared address for read and update
// ----------------------------------------------------------------------------
module mpr_group_file #(
    parameter int MAX_LEN = 20,
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int CW = $clog2(MAX_LEN + 1)
) (
    input  logic                 i_clk,
    input  mpr_pkg::t_gf_op      i_op,
    input  logic [IW-1:0]        i_addr,
    output logic [CW-1:0]        o_rdata
);

    logic [CW-1:0] r_cnt [MAX_LEN];

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            mpr_pkg::GF_CLR: begin
                for (int x = 0; x < MAX_LEN; x++) begin
                    r_cnt[x] <= '0;
                end
            end
            mpr_pkg::GF_INC: r_cnt[i_addr] <= r_cnt[i_addr] + 1'b1;
            mpr_pkg::GF_DEC: r_cnt[i_addr] <= r_cnt[i_addr] - 1'b1;
            default: ;
        endcase
    end

    assign o_rdata = r_cnt[i_addr];

endmodule

FILE: rtl/core/mpr_engine.sv
// ----------------------------------------------------------------------------
// mpr_engine
// sequencer and datapath registers: init pass, per-word rank update
// ----------------------------------------------------------------------------
module mpr_engine #(
    parameter int MAX_LEN = 20,
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int CW = $clog2(MAX_LEN + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_restart,
    input  logic [mpr_pkg::LEN_W-1:0]   i_seq_len,
    input  logic [mpr_pkg::LEN_W-1:0]   i_group_size,
    input  logic                        i_sym_valid,
    input  logic [mpr_pkg::SYM_W-1:0]   i_symbol,
    output logic                        o_sym_ready,
    input  logic                        i_out_free,
    output mpr_pkg::t_result            o_result,
    output mpr_pkg::t_md_req            o_md_req,
    input  mpr_pkg::t_md_rsp            i_md_rsp,
    output mpr_pkg::t_gf_op             o_gf_op,
    output logic [IW-1:0]               o_gf_addr,
    input  logic [CW-1:0]               i_gf_rdata
);

    localparam int MW = mpr_pkg::SYM_W + mpr_pkg::LEN_W;
    localparam int LW = mpr_pkg::LEN_W;

    mpr_pkg::t_state            r_state, n_state;
    logic [mpr_pkg::RANK_W-1:0] r_m, n_m;
    logic [mpr_pkg::RANK_W-1:0] r_rank, n_rank;
    logic                       r_fail, n_fail;
    logic [LW-1:0]              r_pos, n_pos;
    logic [LW-1:0]              r_t, n_t;
    logic [LW-1:0]              r_j, n_j;
    logic [IW-1:0]              r_c, n_c;
    logic [IW-1:0]              r_g, n_g;
    logic [IW-1:0]              r_k, n_k;
    logic [CW-1:0]              r_sum, n_sum;

    logic [LW-1:0]              w_n;
    logic [LW-1:0]              w_d;
    logic [LW-1:0]              w_m;
    logic [MW-1:0]              w_kd;
    logic                       w_k_ok;
    logic                       w_accept;

    assign w_n = (i_seq_len == '0) ? LW'(1) :
                 (i_seq_len > LW'(MAX_LEN)) ? LW'(MAX_LEN) : i_seq_len;
    assign w_d = (i_group_size == '0) ? LW'(1) : i_group_size;
    assign w_m = w_n - r_pos;
    assign w_kd = MW'(i_symbol) * MW'(w_d);
    assign w_k_ok = w_kd < MW'(w_n);
    assign w_accept = (r_state == mpr_pkg::ST_IDLE) && i_sym_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpr_pkg::ST_CLR:       n_state = mpr_pkg::ST_INIT_MUL;
            mpr_pkg::ST_INIT_MUL:  n_state = mpr_pkg::ST_INIT_WAIT;
            mpr_pkg::ST_INIT_WAIT: begin
                if (i_md_rsp.done) begin
                    n_state = (LW'(r_t + 1'b1) == w_n) ? mpr_pkg::ST_IDLE
                                                       : mpr_pkg::ST_INIT_MUL;
                end
            end
            mpr_pkg::ST_IDLE: begin
                if (i_sym_valid) begin
                    n_state = (r_fail || !w_k_ok) ? mpr_pkg::ST_ADVANCE : mpr_pkg::ST_SUM;
                end
            end
            mpr_pkg::ST_SUM: begin
                if (r_g == r_k) begin
                    n_state = (i_gf_rdata == '0) ? mpr_pkg::ST_ADVANCE
                                                 : mpr_pkg::ST_RANK_MUL;
                end
            end
            mpr_pkg::ST_RANK_MUL:  n_state = mpr_pkg::ST_RANK_WAIT;
            mpr_pkg::ST_RANK_WAIT: begin
                if (i_md_rsp.done) n_state = mpr_pkg::ST_NEXT_MUL;
            end
            mpr_pkg::ST_NEXT_MUL:  n_state = mpr_pkg::ST_NEXT_WAIT;
            mpr_pkg::ST_NEXT_WAIT: begin
                if (i_md_rsp.done) n_state = mpr_pkg::ST_ADVANCE;
            end
            mpr_pkg::ST_ADVANCE: begin
                n_state = (LW'(r_pos + 1'b1) >= w_n) ? mpr_pkg::ST_DONE : mpr_pkg::ST_IDLE;
            end
            mpr_pkg::ST_DONE: begin
                if (i_out_free) n_state = mpr_pkg::ST_CLR;
            end
            default: n_state = mpr_pkg::ST_CLR;
        endcase
        if (i_restart) n_state = mpr_pkg::ST_CLR;
    end

    // outputs
    always_comb begin
        o_sym_ready     = (r_state == mpr_pkg::ST_IDLE);
        o_md_req.start  = 1'b0;
        o_md_req.a      = r_m;
        o_md_req.b      = LW'(r_t + 1'b1);
        o_md_req.c      = LW'(r_j + 1'b1);
        o_gf_op         = mpr_pkg::GF_HOLD;
        o_gf_addr       = r_g;
        o_result.valid  = (r_state == mpr_pkg::ST_DONE) && i_out_free;
        o_result.rank   = r_fail ? '0 : r_rank;
        o_result.failed = r_fail;
        unique case (r_state)
            mpr_pkg::ST_CLR: o_gf_op = mpr_pkg::GF_CLR;
            mpr_pkg::ST_INIT_MUL: begin
                o_md_req.start = 1'b1;
                o_gf_op        = mpr_pkg::GF_INC;
                o_gf_addr      = r_c;
            end
            mpr_pkg::ST_RANK_MUL: begin
                o_md_req.start = 1'b1;
                o_md_req.b     = LW'(r_sum);
                o_md_req.c     = w_m;
            end
            mpr_pkg::ST_NEXT_MUL: begin
                o_md_req.start = 1'b1;
                o_md_req.b     = LW'(i_gf_rdata);
                o_md_req.c     = w_m;
                o_gf_op        = mpr_pkg::GF_DEC;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_m    = r_m;
        n_rank = r_rank;
        n_fail = r_fail;
        n_pos  = r_pos;
        n_t    = r_t;
        n_j    = r_j;
        n_c    = r_c;
        n_g    = r_g;
        n_k    = r_k;
        n_sum  = r_sum;
        unique case (r_state)
            mpr_pkg::ST_CLR: begin
                n_m    = mpr_pkg::RANK_W'(1);
                n_rank = '0;
                n_fail = 1'b0;
                n_pos  = '0;
                n_t    = '0;
                n_j    = '0;
                n_c    = '0;
            end
            mpr_pkg::ST_INIT_WAIT: begin
                if (i_md_rsp.done) begin
                    n_m = i_md_rsp.quot;
                    n_t = r_t + 1'b1;
                    if (LW'(r_j + 1'b1) == w_d) begin
                        n_j = '0;
                        n_c = r_c + 1'b1;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            mpr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_k   = i_symbol[IW-1:0];
                    n_g   = '0;
                    n_sum = '0;
                    if (!w_k_ok) n_fail = 1'b1;
                end
            end
            mpr_pkg::ST_SUM: begin
                if (r_g == r_k) begin
                    if (i_gf_rdata == '0) n_fail = 1'b1;
                end else begin
                    n_sum = r_sum + i_gf_rdata;
                    n_g   = r_g + 1'b1;
                end
            end
            mpr_pkg::ST_RANK_WAIT: begin
                if (i_md_rsp.done) n_rank = r_rank + i_md_rsp.quot;
            end
            mpr_pkg::ST_NEXT_WAIT: begin
                if (i_md_rsp.done) n_m = i_md_rsp.quot;
            end
            mpr_pkg::ST_ADVANCE: n_pos = r_pos + 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpr_pkg::ST_CLR;
            r_fail  <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_fail  <= n_fail;
            r_pos   <= n_pos;
        end
        r_m    <= n_m;
        r_rank <= n_rank;
        r_t    <= n_t;
        r_j    <= n_j;
        r_c    <= n_c;
        r_g    <= n_g;
        r_k    <= n_k;
        r_sum  <= n_sum;
    end

endmodule

FILE: rtl/core/multiset_permutation_rank_core.sv
// ----------------------------------------------------------------------------
// multiset_permutation_rank_core
// lexicographic rank of a symbol sequence among arrangements of a multiset
// ----------------------------------------------------------------------------
// Takes one color symbol per input word and, after seq_length words, returns
// one word with the sequence's rank (zero when failed) and a failed flag in
// tuser. The multinomial count of the remaining positions is kept in a
// register; each symbol k costs one scan over colors below k and two passes
// through the shared multiply/exact-divide unit; a symbol that is out of range
// or follows a failure skips both. After reset, a register write or each
// result the core rebuilds the counts in an init pass during which s_tready
// is low; register writes are taken at any time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multiset_permutation_rank_core #(
    parameter int MAX_LEN = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // word: symbol [7:0]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mpr_pkg::SYM_W-1:0]     s_tdata,
    // word: rank [61:0], zero fill [63:62]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mpr_pkg::DATA_W-1:0]    m_tdata,
    // failed [0]
    output logic                          m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mpr_pkg::APB_AW-1:0]    paddr,
    input  logic [mpr_pkg::APB_DW-1:0]    pwdata,
    output logic [mpr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [mpr_pkg::LEN_W-1:0]  r_seq_len;
    logic [mpr_pkg::LEN_W-1:0]  r_group_size;
    logic                       r_out_valid;
    logic [mpr_pkg::RANK_W-1:0] r_out_rank;
    logic                       r_out_failed;

    logic                       w_cfg_wr;
    logic [0:0]                 w_reg_idx;
    logic                       w_out_free;
    mpr_pkg::t_result           w_result;
    mpr_pkg::t_md_req           w_md_req;
    mpr_pkg::t_md_rsp           w_md_rsp;
    mpr_pkg::t_gf_op            w_gf_op;
    logic [IW-1:0]              w_gf_addr;
    logic [CW-1:0]              w_gf_rdata;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[2:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len    <= mpr_pkg::SEQ_LEN_RST;
            r_group_size <= mpr_pkg::GROUP_SIZE_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                mpr_pkg::REG_SEQ_LEN:    r_seq_len    <= pwdata[mpr_pkg::LEN_W-1:0];
                mpr_pkg::REG_GROUP_SIZE: r_group_size <= pwdata[mpr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            mpr_pkg::REG_SEQ_LEN:
                prdata = {{(mpr_pkg::APB_DW - mpr_pkg::LEN_W){1'b0}}, r_seq_len};
            mpr_pkg::REG_GROUP_SIZE:
                prdata = {{(mpr_pkg::APB_DW - mpr_pkg::LEN_W){1'b0}}, r_group_size};
            default: prdata = '0;
        endcase
    end

    assign w_out_free = !r_out_valid || m_tready;

    mpr_engine #(
        .MAX_LEN (MAX_LEN)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (w_cfg_wr),
        .i_seq_len    (r_seq_len),
        .i_group_size (r_group_size),
        .i_sym_valid  (s_tvalid),
        .i_symbol     (s_tdata),
        .o_sym_ready  (s_tready),
        .i_out_free   (w_out_free),
        .o_result     (w_result),
        .o_md_req     (w_md_req),
        .i_md_rsp     (w_md_rsp),
        .o_gf_op      (w_gf_op),
        .o_gf_addr    (w_gf_addr),
        .i_gf_rdata   (w_gf_rdata)
    );

    mpr_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_rsp   (w_md_rsp)
    );

    mpr_group_file #(
        .MAX_LEN (MAX_LEN)
    ) u_group_file (
        .i_clk   (i_clk),
        .i_op    (w_gf_op),
        .i_addr  (w_gf_addr),
        .o_rdata (w_gf_rdata)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_result.valid) begin
            r_out_rank   <= w_result.rank;
            r_out_failed <= w_result.failed;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(mpr_pkg::DATA_W - mpr_pkg::RANK_W){1'b0}}, r_out_rank};
    assign m_tuser  = r_out_failed;

    `MPR_ASSERT_NEXT(a_busy_after_word, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready)
    `MPR_ASSERT_NEXT(a_cfg_restarts, i_clk, i_rst_n, w_cfg_wr, !s_tready)
    `MPR_ASSERT(a_fail_zero_rank, i_clk, i_rst_n, m_tvalid && m_tuser |-> m_tdata == '0)

endmodule
